// ===== src/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types, codes and reset constants for the circuit breaker table.
// ----------------------------------------------------------------------------
package cbt_pkg;

    // Default number of breakers in the table.
    localparam int CBT_TARGETS_DEFAULT = 8;

    // Register reset values.
    localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
    localparam logic [31:0] COOLDOWN_RESET  = 32'd30;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_SUCCESS = 2'd1,
        OP_FAILURE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FAILURE_THRESHOLD = 1'b0,
        CFG_COOLDOWN_SECONDS  = 1'b1
    } cfg_reg_t;

    // One breaker as it is kept in the state memory.
    typedef struct packed {
        logic [7:0]  failure_count;
        logic        is_open;
        logic [31:0] open_stamp;
        logic        probe_out;
    } entry_t;

    // One incoming request.
    typedef struct packed {
        op_t         operation;
        logic [2:0]  target_index;
        logic [31:0] now_seconds;
    } item_t;

    // One result.
    typedef struct packed {
        logic       allowed;
        logic       cooling_down;
        logic [7:0] failures;
    } result_t;

endpackage

// ===== src/cbt_if.sv =====
// ----------------------------------------------------------------------------
// cbt_if
// Valid/ready channels for incoming requests and outgoing results.
// ----------------------------------------------------------------------------
interface cbt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [2:0]  target_index;
    logic [31:0] now_seconds;

    modport source (output valid, output operation, output target_index,
                    output now_seconds, input ready);
    modport sink   (input valid, input operation, input target_index,
                    input now_seconds, output ready);
endinterface

interface cbt_rsp_if;
    logic       valid;
    logic       ready;
    logic       allowed;
    logic       cooling_down;
    logic [7:0] failures;

    modport source (output valid, output allowed, output cooling_down,
                    output failures, input ready);
    modport sink   (input valid, input allowed, input cooling_down,
                    input failures, output ready);
endinterface

// ===== src/cbt_state_mem.sv =====
// ----------------------------------------------------------------------------
// cbt_state_mem
// Breaker state memory with a registered read, write-to-read forwarding and
// per-entry valid bits so that reset and clear-all take effect at once.
// ----------------------------------------------------------------------------
module cbt_state_mem
    import cbt_pkg::*;
#(
    parameter int TARGETS = CBT_TARGETS_DEFAULT,
    parameter int ADDR_W  = (TARGETS > 1) ? $clog2(TARGETS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              clear_all,
    output entry_t            rd_data
);

    entry_t              mem [TARGETS];
    entry_t              rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [TARGETS-1:0]  valid_reg;
    logic [TARGETS-1:0]  valid_next;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    // Valid bits: an entry that was never written since reset or the last
    // clear-all reads as a closed breaker with no failures.
    always_comb
    begin
        valid_next = valid_reg;
        if (clear_all)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_data = valid_reg[rd_addr_reg] ? rd_data_reg : '0;

    // Checks.
    a_no_write_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && clear_all))
        else $error("state write and clear-all in the same cycle");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear_all |=> (valid_reg == '0))
        else $error("valid bits survived a clear-all");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !clear_all) |=> valid_reg[$past(wr_addr)])
        else $error("written entry not marked valid");

endmodule

// ===== src/cbt_update.sv =====
// ----------------------------------------------------------------------------
// cbt_update
// Next-state and result logic for one breaker entry and one request.
// ----------------------------------------------------------------------------
module cbt_update
    import cbt_pkg::*;
(
    input  item_t       item,
    input  logic        in_range,
    input  entry_t      entry,
    input  logic [7:0]  threshold,
    input  logic [31:0] cooldown,
    output entry_t      entry_next,
    output result_t     result
);

    logic [31:0] elapsed;
    logic        cooling_now;
    logic        cooling_after;
    logic        allowed;
    logic [7:0]  count_inc;
    logic        opens;

    // Elapsed time wraps modulo 2^32.
    assign elapsed     = item.now_seconds - entry.open_stamp;
    assign cooling_now = entry.is_open && (elapsed < cooldown);

    // Failure count saturates at the threshold.
    assign count_inc = (entry.failure_count < threshold) ? entry.failure_count + 8'd1
                                                         : entry.failure_count;
    assign opens     = (count_inc >= threshold);

    always_comb
    begin
        entry_next    = entry;
        allowed       = 1'b0;
        cooling_after = cooling_now;
        unique case (item.operation)
            OP_REQUEST:
            begin
                if (!entry.is_open)
                begin
                    allowed = 1'b1;
                end
                else if (!cooling_now && !entry.probe_out)
                begin
                    // Cooldown over: hand out the single half-open probe.
                    entry_next.probe_out = 1'b1;
                    allowed              = 1'b1;
                end
            end
            OP_SUCCESS:
            begin
                entry_next    = '0;
                cooling_after = 1'b0;
            end
            OP_FAILURE:
            begin
                entry_next.failure_count = count_inc;
                entry_next.probe_out     = 1'b0;
                if (opens)
                begin
                    // Freshly stamped, so elapsed time is zero.
                    entry_next.is_open    = 1'b1;
                    entry_next.open_stamp = item.now_seconds;
                    cooling_after         = (cooldown != 32'd0);
                end
            end
            OP_CLEAR:
            begin
                entry_next    = '0;
                cooling_after = 1'b0;
            end
        endcase
    end

    // Result fields; an index beyond the table answers as a closed breaker.
    always_comb
    begin
        if (item.operation == OP_CLEAR)
        begin
            result = '0;
        end
        else if (!in_range)
        begin
            result              = '0;
            result.allowed      = (item.operation == OP_REQUEST);
        end
        else
        begin
            result.allowed      = allowed;
            result.cooling_down = cooling_after;
            result.failures     = entry_next.failure_count;
        end
    end

endmodule

// ===== src/circuit_breaker_table.sv =====
// A request and its state read are registered on accept; its result is
// registered once the result register is free. Throughput: one request per
// cycle unless a result stalls; the state write-back on finish is forwarded.
// A stalled result holds the request in flight and back-pressures the input.
// Reset: threshold 3, cooldown 30, all breakers closed with zero failures;
// per-entry valid bits clear the table at once, with no clearing pass.
// ----------------------------------------------------------------------------
// circuit_breaker_table
// Table of per-target circuit breakers with half-open probing.
// ----------------------------------------------------------------------------
module circuit_breaker_table
    import cbt_pkg::*;
#(
    parameter int TARGETS = CBT_TARGETS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    cbt_req_if.sink      req,
    cbt_rsp_if.source    rsp,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int ADDR_W = (TARGETS > 1) ? $clog2(TARGETS) : 1;

    logic [7:0]   threshold_reg;
    logic [31:0]  cooldown_reg;
    logic         busy_reg;
    logic         busy_next;
    item_t        item_reg;
    logic         rsp_valid_reg;
    logic         rsp_valid_next;
    result_t      rsp_data_reg;

    logic         accept;
    logic         finish;
    logic         in_range;
    entry_t       entry;
    entry_t       entry_next;
    result_t      result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            cooldown_reg  <= COOLDOWN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FAILURE_THRESHOLD: threshold_reg <= cfg_data[7:0];
                CFG_COOLDOWN_SECONDS:  cooldown_reg  <= cfg_data;
            endcase
        end
    end

    // Handshake: a request in flight finishes once the result register is free.
    assign finish    = busy_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !busy_reg || finish;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.operation    <= op_t'(req.operation);
            item_reg.target_index <= req.target_index;
            item_reg.now_seconds  <= req.now_seconds;
        end
        if (finish)
        begin
            rsp_data_reg <= result;
        end
    end

    assign in_range = (int'(item_reg.target_index) < TARGETS);

    // Breaker state memory.
    cbt_state_mem #(
        .TARGETS (TARGETS),
        .ADDR_W  (ADDR_W)
    ) u_state_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (ADDR_W'(req.target_index)),
        .wr_en     (finish && in_range && (item_reg.operation != OP_CLEAR)),
        .wr_addr   (ADDR_W'(item_reg.target_index)),
        .wr_data   (entry_next),
        .clear_all (finish && (item_reg.operation == OP_CLEAR)),
        .rd_data   (entry)
    );

    // Breaker update.
    cbt_update u_update (
        .item       (item_reg),
        .in_range   (in_range),
        .entry      (entry),
        .threshold  (threshold_reg),
        .cooldown   (cooldown_reg),
        .entry_next (entry_next),
        .result     (result)
    );

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.allowed      = rsp_data_reg.allowed;
    assign rsp.cooling_down = rsp_data_reg.cooling_down;
    assign rsp.failures     = rsp_data_reg.failures;

    // Checks.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(busy_reg))
        else $error("result appeared with no request in flight");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && rsp_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request accepted while a stalled one is in flight");

    a_allowed_only_request: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (item_reg.operation != OP_REQUEST)) |-> !result.allowed)
        else $error("allowed set for an operation other than a request");

    a_clear_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (item_reg.operation == OP_CLEAR)) |-> (result == '0))
        else $error("clear-all produced a nonzero result");

endmodule
